@@ hw/rtl/cbt_pba_pkg.sv @@
// shared types and constants for the packed bit-heap access block
// no dependencies; used by every module under hw/rtl but cbt_pba_ram
package cbt_pba_pkg;

    // default sizes handed to the top level parameters
    localparam int DEPTH_LIMIT_DEF = 12;
    localparam int STORE_WORDS_DEF = 512;

    // storage word and item field widths
    localparam int WORD_W   = 32;
    localparam int OFF_W    = 5;
    localparam int PAIR_W   = 2 * WORD_W;
    localparam int FUNC_W   = 2;
    localparam int HIDX_W   = 13;
    localparam int DEPTH_W  = 4;
    localparam int VALUE_W  = 13;
    localparam int RDATA_W  = 13;
    localparam int FWID_W   = DEPTH_W + 1;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_MAX_DEPTH = '0;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 4'd12;

    // request codes
    typedef enum logic [FUNC_W-1:0] {
        FN_WR_SUM  = 2'd0,
        FN_RD_SUM  = 2'd1,
        FN_WR_LEAF = 2'd2,
        FN_RD_LEAF = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_MASK,
        ST_DATA,
        ST_RD0,
        ST_MOD0,
        ST_RD1,
        ST_MOD1,
        ST_EXTR,
        ST_PUSH
    } state_t;

    // control of the shared shifter
    typedef struct packed {
        logic [PAIR_W-1:0] din;
        logic [OFF_W-1:0]  amount;
        logic              shift_right;
    } shift_ctl_t;

endpackage

@@ hw/rtl/cbt_pba_ram.sv @@
// generic single-port ram with registered read data
// no dependencies
module cbt_pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle; read data is registered and appears in the next cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/cbt_pba_shifter.sv @@
// shared 64-bit shift unit: builds field masks and data, extracts read fields
// depends on cbt_pba_pkg
module cbt_pba_shifter (
    input  cbt_pba_pkg::shift_ctl_t                 ctl,
    output logic [cbt_pba_pkg::PAIR_W-1:0]          dout
);

    // left to place a field at its bit offset, right to bring it down to bit 0
    always_comb begin
        if (ctl.shift_right) begin
            dout = ctl.din >> ctl.amount;
        end else begin
            dout = ctl.din << ctl.amount;
        end
    end

endmodule

@@ hw/rtl/cbt_pba_cfg.sv @@
// apb register file holding max_depth, with the clamped leaf depth output
// depends on cbt_pba_pkg
module cbt_pba_cfg #(
    parameter int DEPTH_LIMIT = cbt_pba_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cbt_pba_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbt_pba_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbt_pba_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                   pready,
    output logic [cbt_pba_pkg::DEPTH_W-1:0]        md
);

    logic [cbt_pba_pkg::DEPTH_W-1:0] max_depth_reg;
    logic [cbt_pba_pkg::DEPTH_W-1:0] max_depth_next;
    logic                            sel_max_depth;

    assign pready        = 1'b1;
    assign sel_max_depth = (paddr[cbt_pba_pkg::APB_ADDR_W-1:2] == cbt_pba_pkg::REG_MAX_DEPTH);

    // register write in the access phase
    always_comb begin
        max_depth_next = max_depth_reg;
        if (psel && penable && pwrite && pready && sel_max_depth) begin
            max_depth_next = pwdata[cbt_pba_pkg::DEPTH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg <= cbt_pba_pkg::MAX_DEPTH_RST;
        end else begin
            max_depth_reg <= max_depth_next;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (sel_max_depth) begin
            prdata = cbt_pba_pkg::APB_DATA_W'(max_depth_reg);
        end
    end

    // clamp to 1 .. DEPTH_LIMIT
    always_comb begin
        if (max_depth_reg == '0) begin
            md = cbt_pba_pkg::DEPTH_W'(1);
        end else if (32'(max_depth_reg) > 32'(DEPTH_LIMIT)) begin
            md = cbt_pba_pkg::DEPTH_W'(DEPTH_LIMIT);
        end else begin
            md = max_depth_reg;
        end
    end

endmodule

@@ hw/rtl/cbt_packed_bitheap_access.sv @@
// steps: an accepted item passes CALC, MASK, DATA, RD0, MOD0, then RD1 and MOD1 if the field
// spans two words, then EXTR and PUSH; a node below the leaf level goes from CALC to EXTR;
// a result still waiting on m_tready holds the sequencer in PUSH, and a new item is taken
// only in IDLE; each touched store word gets a read and a merge state around one shared shifter
// reset: synchronous, active low; a clearing pass zeroes the store word by word,
// during which no item is accepted (register writes are taken); max_depth resets to 12
module cbt_packed_bitheap_access #(
    parameter int DEPTH_LIMIT = cbt_pba_pkg::DEPTH_LIMIT_DEF,
    parameter int STORE_WORDS = cbt_pba_pkg::STORE_WORDS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // func [1:0], heap_index [14:2], depth [18:15], value [31:19]
    input  logic [cbt_pba_pkg::S_DATA_W-1:0]       s_tdata,
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // read_data [12:0], zero fill [15:13]
    output logic [cbt_pba_pkg::M_DATA_W-1:0]       m_tdata,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cbt_pba_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbt_pba_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbt_pba_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                   pready
);

    localparam int ADDR_W = $clog2(STORE_WORDS);
    localparam int MD_MAX = (DEPTH_LIMIT < 15) ? DEPTH_LIMIT : 15;
    localparam int POS_W  = MD_MAX + 18;
    localparam int WI_W   = POS_W - cbt_pba_pkg::OFF_W;
    localparam int WORD_W = cbt_pba_pkg::WORD_W;
    localparam int PAIR_W = cbt_pba_pkg::PAIR_W;
    localparam int FWID_W = cbt_pba_pkg::FWID_W;

    cbt_pba_pkg::state_t state_reg, state_next;

    // captured request
    cbt_pba_pkg::func_t                    func_reg, func_next;
    logic [cbt_pba_pkg::HIDX_W-1:0]        hidx_reg, hidx_next;
    logic [cbt_pba_pkg::DEPTH_W-1:0]       depth_reg, depth_next;
    logic [cbt_pba_pkg::VALUE_W-1:0]       value_reg, value_next;

    // decoded access
    logic [FWID_W-1:0]                     w_reg, w_next;
    logic [cbt_pba_pkg::OFF_W-1:0]         off_reg, off_next;
    logic [WI_W-1:0]                       wi_reg, wi_next;
    logic                                  ok0_reg, ok0_next;
    logic                                  ok1_reg, ok1_next;
    logic                                  span_reg, span_next;
    logic [PAIR_W-1:0]                     mask_reg, mask_next;
    logic [PAIR_W-1:0]                     data_reg, data_next;
    logic [PAIR_W-1:0]                     pair_reg, pair_next;
    logic [cbt_pba_pkg::RDATA_W-1:0]       result_reg, result_next;

    // output register
    logic                                  out_valid_reg, out_valid_next;
    logic [cbt_pba_pkg::RDATA_W-1:0]       out_data_reg, out_data_next;

    // clearing pass
    logic [ADDR_W-1:0]                     clr_cnt_reg, clr_cnt_next;
    logic                                  clr_last;

    // store and shifter hookup
    logic                                  ram_we;
    logic [ADDR_W-1:0]                     ram_addr;
    logic [WORD_W-1:0]                     ram_wdata;
    logic [WORD_W-1:0]                     ram_rdata;
    cbt_pba_pkg::shift_ctl_t               sh_ctl;
    logic [PAIR_W-1:0]                     sh_out;

    // misc decode
    logic [cbt_pba_pkg::DEPTH_W-1:0]       md;
    logic                                  is_write;
    logic                                  is_leaf;
    logic [PAIR_W-1:0]                     low_mask;
    logic [WORD_W-1:0]                     cur_word;
    logic [WORD_W-1:0]                     cur_mask;
    logic [WORD_W-1:0]                     cur_data;
    logic [FWID_W-1:0]                     calc_w;
    logic [POS_W-1:0]                      calc_pos;
    logic [cbt_pba_pkg::OFF_W:0]           end_bit;

    cbt_pba_cfg #(
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .md      (md)
    );

    cbt_pba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    cbt_pba_shifter u_shift (
        .ctl  (sh_ctl),
        .dout (sh_out)
    );

    assign is_write = (func_reg == cbt_pba_pkg::FN_WR_SUM) ||
                      (func_reg == cbt_pba_pkg::FN_WR_LEAF);
    assign is_leaf  = (func_reg == cbt_pba_pkg::FN_WR_LEAF) ||
                      (func_reg == cbt_pba_pkg::FN_RD_LEAF);
    assign low_mask = ~({PAIR_W{1'b1}} << w_reg);
    assign clr_last = (clr_cnt_reg == ADDR_W'(STORE_WORDS - 1));

    // bit position of the node's field or leaf bit
    always_comb begin
        calc_w = is_leaf ? FWID_W'(1) : (FWID_W'(md) - FWID_W'(depth_reg) + FWID_W'(1));
        if (is_leaf) begin
            calc_pos = (POS_W'(1) << (FWID_W'(md) + FWID_W'(1))) +
                       (POS_W'(hidx_reg) << (md - depth_reg));
        end else begin
            calc_pos = (POS_W'(1) << (FWID_W'(depth_reg) + FWID_W'(1))) +
                       POS_W'(hidx_reg) * POS_W'(calc_w);
        end
        end_bit = (cbt_pba_pkg::OFF_W + 1)'(calc_pos[cbt_pba_pkg::OFF_W-1:0]) +
                  (cbt_pba_pkg::OFF_W + 1)'(calc_w);
    end

    // word currently in the merge step
    always_comb begin
        if (state_reg == cbt_pba_pkg::ST_MOD1) begin
            cur_word = ok1_reg ? ram_rdata : '0;
            cur_mask = mask_reg[PAIR_W-1:WORD_W];
            cur_data = data_reg[PAIR_W-1:WORD_W];
        end else begin
            cur_word = ok0_reg ? ram_rdata : '0;
            cur_mask = mask_reg[WORD_W-1:0];
            cur_data = data_reg[WORD_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbt_pba_pkg::ST_CLEAR: if (clr_last) state_next = cbt_pba_pkg::ST_IDLE;
            cbt_pba_pkg::ST_IDLE:  if (s_tvalid) state_next = cbt_pba_pkg::ST_CALC;
            cbt_pba_pkg::ST_CALC: begin
                if (depth_reg <= md) begin
                    state_next = cbt_pba_pkg::ST_MASK;
                end else begin
                    state_next = cbt_pba_pkg::ST_EXTR;
                end
            end
            cbt_pba_pkg::ST_MASK:  state_next = cbt_pba_pkg::ST_DATA;
            cbt_pba_pkg::ST_DATA:  state_next = cbt_pba_pkg::ST_RD0;
            cbt_pba_pkg::ST_RD0:   state_next = cbt_pba_pkg::ST_MOD0;
            cbt_pba_pkg::ST_MOD0: begin
                if (span_reg) begin
                    state_next = cbt_pba_pkg::ST_RD1;
                end else begin
                    state_next = cbt_pba_pkg::ST_EXTR;
                end
            end
            cbt_pba_pkg::ST_RD1:   state_next = cbt_pba_pkg::ST_MOD1;
            cbt_pba_pkg::ST_MOD1:  state_next = cbt_pba_pkg::ST_EXTR;
            cbt_pba_pkg::ST_EXTR:  state_next = cbt_pba_pkg::ST_PUSH;
            cbt_pba_pkg::ST_PUSH: begin
                if (!out_valid_reg || m_tready) state_next = cbt_pba_pkg::ST_IDLE;
            end
            default:               state_next = cbt_pba_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: store port, shifter, handshake
    always_comb begin
        s_tready         = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = ADDR_W'(wi_reg);
        ram_wdata        = (cur_word & ~cur_mask) | cur_data;
        sh_ctl.din       = low_mask;
        sh_ctl.amount    = off_reg;
        sh_ctl.shift_right = 1'b0;
        case (state_reg)
            cbt_pba_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            cbt_pba_pkg::ST_IDLE: s_tready = 1'b1;
            cbt_pba_pkg::ST_DATA: sh_ctl.din = PAIR_W'(value_reg) & low_mask;
            cbt_pba_pkg::ST_MOD0: ram_we = is_write && ok0_reg;
            cbt_pba_pkg::ST_RD1:  ram_addr = ADDR_W'(wi_reg + WI_W'(1));
            cbt_pba_pkg::ST_MOD1: begin
                ram_addr = ADDR_W'(wi_reg + WI_W'(1));
                ram_we   = is_write && ok1_reg;
            end
            cbt_pba_pkg::ST_EXTR: begin
                sh_ctl.din         = pair_reg;
                sh_ctl.shift_right = 1'b1;
            end
            default: ;
        endcase
    end

    // datapath register updates
    always_comb begin
        func_next      = func_reg;
        hidx_next      = hidx_reg;
        depth_next     = depth_reg;
        value_next     = value_reg;
        w_next         = w_reg;
        off_next       = off_reg;
        wi_next        = wi_reg;
        ok0_next       = ok0_reg;
        ok1_next       = ok1_reg;
        span_next      = span_reg;
        mask_next      = mask_reg;
        data_next      = data_reg;
        pair_next      = pair_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        clr_cnt_next   = clr_cnt_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cbt_pba_pkg::ST_CLEAR: clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            cbt_pba_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = cbt_pba_pkg::func_t'(s_tdata[1:0]);
                    hidx_next  = s_tdata[14:2];
                    depth_next = s_tdata[18:15];
                    value_next = s_tdata[31:19];
                end
            end
            cbt_pba_pkg::ST_CALC: begin
                w_next      = calc_w;
                off_next    = calc_pos[cbt_pba_pkg::OFF_W-1:0];
                wi_next     = calc_pos[POS_W-1:cbt_pba_pkg::OFF_W];
                ok0_next    = (64'(calc_pos[POS_W-1:cbt_pba_pkg::OFF_W]) < 64'(STORE_WORDS));
                ok1_next    = (64'(calc_pos[POS_W-1:cbt_pba_pkg::OFF_W]) + 64'd1 <
                               64'(STORE_WORDS));
                span_next   = (end_bit > (cbt_pba_pkg::OFF_W + 1)'(WORD_W));
                pair_next   = '0;
            end
            cbt_pba_pkg::ST_MASK: mask_next = sh_out;
            cbt_pba_pkg::ST_DATA: data_next = sh_out;
            cbt_pba_pkg::ST_MOD0: begin
                if (!is_write) pair_next[WORD_W-1:0] = cur_word & cur_mask;
            end
            cbt_pba_pkg::ST_MOD1: begin
                if (!is_write) pair_next[PAIR_W-1:WORD_W] = cur_word & cur_mask;
            end
            cbt_pba_pkg::ST_EXTR: result_next = sh_out[cbt_pba_pkg::RDATA_W-1:0];
            cbt_pba_pkg::ST_PUSH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cbt_pba_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        hidx_reg     <= hidx_next;
        depth_reg    <= depth_next;
        value_reg    <= value_next;
        w_reg        <= w_next;
        off_reg      <= off_next;
        wi_reg       <= wi_next;
        ok0_reg      <= ok0_next;
        ok1_reg      <= ok1_next;
        span_reg     <= span_next;
        mask_reg     <= mask_next;
        data_reg     <= data_next;
        pair_reg     <= pair_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    // result channel; a request below the leaf level reports zero
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cbt_pba_pkg::M_DATA_W'(out_data_reg);

endmodule

@@ sim/cbt_packed_bitheap_access_tb.sv @@
// self-checking testbench for the packed bit-heap access block
// drives stream items and apb register writes; depends on cbt_pba_pkg and the rtl top only
`timescale 1ns / 1ps

module cbt_packed_bitheap_access_tb;

    localparam int HEAP_WORDS = cbt_pba_pkg::STORE_WORDS_DEF;
    localparam int MAX_LEVEL  = cbt_pba_pkg::DEPTH_LIMIT_DEF;
    localparam logic [cbt_pba_pkg::APB_ADDR_W-1:0] MAX_DEPTH_ADDR =
        {cbt_pba_pkg::REG_MAX_DEPTH, 2'b00};
    localparam int PHASE_ITEMS = 210;
    localparam int N_ROWS = 25;

    // directed row: request fields, plus an optional typed-in read_data
    typedef struct packed {
        cbt_pba_pkg::func_t fn;
        logic [12:0]        hidx;
        logic [3:0]         dep;
        logic [12:0]        val;
        logic               known;
        logic [12:0]        rd;
    } heap_row_t;

    typedef struct packed {
        logic [12:0] hidx;
        logic [3:0]  dep;
    } node_t;

    // fixed requests at the reset depth of 12 on a cleared store
    localparam heap_row_t DIR_ROWS [N_ROWS] = '{
        '{cbt_pba_pkg::FN_RD_SUM,  13'd1,    4'd0,  13'd0,    1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_LEAF, 13'd8191, 4'd12, 13'd0,    1'b1, 13'd0},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd1,    4'd0,  13'd8191, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd1,    4'd0,  13'd0,    1'b1, 13'd8191},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd8191, 4'd12, 13'd8191, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_LEAF, 13'd8191, 4'd12, 13'd0,    1'b1, 13'd1},
        '{cbt_pba_pkg::FN_WR_LEAF, 13'd8191, 4'd12, 13'd8190, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd8191, 4'd12, 13'd0,    1'b1, 13'd0},
        '{cbt_pba_pkg::FN_WR_LEAF, 13'd1,    4'd0,  13'd1,    1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_LEAF, 13'd1,    4'd0,  13'd0,    1'b1, 13'd1},
        '{cbt_pba_pkg::FN_RD_LEAF, 13'd4096, 4'd12, 13'd0,    1'b1, 13'd1},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd5,    4'd2,  13'd2047, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd5,    4'd2,  13'd0,    1'b1, 13'd2047},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd4,    4'd2,  13'd0,    1'b0, 13'd0},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd1488, 4'd2,  13'd2047, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd1488, 4'd2,  13'd0,    1'b1, 13'd255},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd8191, 4'd0,  13'd341,  1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd8191, 4'd0,  13'd0,    1'b1, 13'd0},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd3,    4'd13, 13'd8191, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd1,    4'd15, 13'd0,    1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_LEAF, 13'd0,    4'd0,  13'd0,    1'b0, 13'd0},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd0,    4'd0,  13'd2730, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd0,    4'd0,  13'd0,    1'b0, 13'd0},
        '{cbt_pba_pkg::FN_WR_SUM,  13'd2,    4'd1,  13'd5461, 1'b1, 13'd0},
        '{cbt_pba_pkg::FN_RD_SUM,  13'd2,    4'd1,  13'd0,    1'b0, 13'd0}
    };

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [cbt_pba_pkg::S_DATA_W-1:0]   s_tdata;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [cbt_pba_pkg::M_DATA_W-1:0]   m_tdata;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [cbt_pba_pkg::APB_ADDR_W-1:0] paddr;
    logic [cbt_pba_pkg::APB_DATA_W-1:0] pwdata;
    logic [cbt_pba_pkg::APB_DATA_W-1:0] prdata;
    logic                               pready;

    // predictor state: store image and the max_depth register
    logic [31:0] heap_words [HEAP_WORDS];
    logic [3:0]  depth_reg;
    logic [12:0] pending_reads [$];
    node_t       recent_nodes [$];
    int          fault_count = 0;
    bit          steady = 1'b0;

    cbt_packed_bitheap_access dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("cbt_packed_bitheap_access test failed");
        $finish;
    end

    // store word with out-of-range words reading as zero
    function automatic logic [31:0] word_at(input longint unsigned wi);
        if (wi >= HEAP_WORDS) return 32'd0;
        return heap_words[wi];
    endfunction

    function automatic logic [31:0] get_bits(input longint unsigned pos, input int unsigned w);
        longint unsigned wi;
        logic [63:0] pair;
        logic [63:0] mask;
        wi = pos / 32;
        pair = {word_at(wi + 1), word_at(wi)};
        mask = (64'd1 << w) - 64'd1;
        return 32'((pair >> (pos % 32)) & mask);
    endfunction

    // read-modify-write of one or two words; words past the store are dropped
    function automatic void put_bits(input longint unsigned pos, input int unsigned w,
                                     input logic [31:0] v);
        longint unsigned wi;
        int unsigned off;
        logic [63:0] pair;
        logic [63:0] mask;
        wi = pos / 32;
        off = int'(pos % 32);
        pair = {word_at(wi + 1), word_at(wi)};
        mask = (64'd1 << w) - 64'd1;
        pair = (pair & ~(mask << off)) | (({32'd0, v} & mask) << off);
        if (wi < HEAP_WORDS) heap_words[wi] = pair[31:0];
        if (off + w > 32 && wi + 1 < HEAP_WORDS) heap_words[wi + 1] = pair[63:32];
    endfunction

    // applies one request to the store image, returns read_data
    function automatic logic [12:0] heap_access(input logic [31:0] word);
        cbt_pba_pkg::func_t fn;
        longint unsigned hidx;
        int unsigned dep;
        int unsigned md;
        int unsigned w;
        logic [12:0] val;
        longint unsigned fpos;
        longint unsigned lpos;
        logic [31:0] got;
        fn = cbt_pba_pkg::func_t'(word[1:0]);
        hidx = word[14:2];
        dep = word[18:15];
        val = word[31:19];
        md = depth_reg;
        if (md < 1) md = 1;
        if (md > MAX_LEVEL) md = MAX_LEVEL;
        got = 32'd0;
        if (dep <= md) begin
            w = md - dep + 1;
            fpos = (64'd1 << (dep + 1)) + hidx * w;
            lpos = (64'd1 << (md + 1)) + (hidx << (md - dep));
            case (fn)
                cbt_pba_pkg::FN_WR_SUM:  put_bits(fpos, w, {19'd0, val});
                cbt_pba_pkg::FN_RD_SUM:  got = get_bits(fpos, w);
                cbt_pba_pkg::FN_WR_LEAF: put_bits(lpos, 1, {31'd0, val[0]});
                default:                 got = get_bits(lpos, 1);
            endcase
        end
        return got[12:0];
    endfunction

    // one item on the input side; prediction at acceptance
    task automatic send_item(input cbt_pba_pkg::func_t fn, input logic [12:0] hidx,
                             input logic [3:0] dep, input logic [12:0] val,
                             input logic known, input logic [12:0] rd);
        logic [31:0] word;
        logic [12:0] predicted;
        word = {val, dep, hidx, fn};
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        predicted = heap_access(word);
        pending_reads.push_back(known ? rd : predicted);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
    endtask

    // apb write then read back
    task automatic set_max_depth(input logic [3:0] md);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= MAX_DEPTH_ADDR; pwdata <= {28'd0, md};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        depth_reg = md;
        @(negedge aclk);
        penable <= 1'b0; pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[3:0] !== md) begin
            $display("%0t: max_depth readback expected %0d actual %0d", $time, md, prdata[3:0]);
            fault_count++;
        end
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    // mostly well-formed nodes on the active levels, some re-reads, some noise
    task automatic run_phase(input logic [3:0] md, input bit calm);
        int unsigned lim;
        int unsigned r;
        int unsigned d;
        cbt_pba_pkg::func_t fn;
        logic [12:0] hidx;
        logic [3:0] dep;
        logic [12:0] val;
        node_t pick;
        drain();
        set_max_depth(md);
        steady = calm;
        lim = (md < 1) ? 1 : (md > MAX_LEVEL) ? MAX_LEVEL : md;
        recent_nodes.delete();
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            val = 13'($urandom_range(0, 8191));
            if (r < 30 && recent_nodes.size() > 0) begin
                pick = recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
                hidx = pick.hidx;
                dep = pick.dep;
                fn = $urandom_range(0, 1) ? cbt_pba_pkg::FN_RD_SUM : cbt_pba_pkg::FN_RD_LEAF;
            end else if (r < 82) begin
                d = $urandom_range(0, lim);
                dep = 4'(d);
                hidx = 13'((1 << d) | $urandom_range(0, (1 << d) - 1));
                fn = cbt_pba_pkg::func_t'($urandom_range(0, 3));
                if (fn == cbt_pba_pkg::FN_WR_SUM || fn == cbt_pba_pkg::FN_WR_LEAF) begin
                    recent_nodes.push_back('{hidx, dep});
                    if (recent_nodes.size() > 16) void'(recent_nodes.pop_front());
                end
            end else begin
                hidx = 13'($urandom_range(0, 8191));
                dep = 4'($urandom_range(0, 15));
                fn = cbt_pba_pkg::func_t'($urandom_range(0, 3));
            end
            send_item(fn, hidx, dep, val, 1'b0, 13'd0);
        end
    endtask

    // result side ready
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    // compare each result with the oldest expected read_data
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0d",
                         $time, m_tdata[12:0]);
                fault_count++;
            end else begin
                logic [12:0] want;
                want = pending_reads.pop_front();
                if (m_tdata[12:0] !== want) begin
                    $display("%0t: read_data expected %0d actual %0d",
                             $time, want, m_tdata[12:0]);
                    fault_count++;
                end
            end
        end
    end

    // reset, directed rows, random phases, end check
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        depth_reg = cbt_pba_pkg::MAX_DEPTH_RST;
        for (int i = 0; i < HEAP_WORDS; i++) heap_words[i] = 32'd0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of the register
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= MAX_DEPTH_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[3:0] !== cbt_pba_pkg::MAX_DEPTH_RST) begin
            $display("%0t: max_depth after reset expected %0d actual %0d",
                     $time, cbt_pba_pkg::MAX_DEPTH_RST, prdata[3:0]);
            fault_count++;
        end
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0;

        for (int i = 0; i < N_ROWS; i++)
            send_item(DIR_ROWS[i].fn, DIR_ROWS[i].hidx, DIR_ROWS[i].dep, DIR_ROWS[i].val,
                      DIR_ROWS[i].known, DIR_ROWS[i].rd);

        run_phase(4'd1, 1'b0);
        run_phase(4'd0, 1'b0);
        run_phase(4'd12, 1'b0);
        run_phase(4'd15, 1'b0);
        run_phase(4'd5, 1'b1);
        run_phase(4'd9, 1'b0);
        run_phase(4'd3, 1'b0);
        run_phase(4'd12, 1'b0);

        drain();
        repeat (24) @(posedge aclk);
        if (fault_count == 0) begin
            $display("cbt_packed_bitheap_access test passed");
        end else begin
            $display("cbt_packed_bitheap_access test failed");
        end
        $finish;
    end

endmodule
